/* rtl/core/ilp_pkg.sv */
// shared types and constants for the intercept lead point unit
package ilp_pkg;

  localparam int RAD_W  = 96;
  localparam int ROOT_W = 48;
  localparam int REM_W  = 51;
  localparam int PS_W   = 51;
  localparam int NUM_W  = 75;
  localparam int T_W    = 46;
  localparam int QUO_W  = 42;
  localparam int CAP_B  = 41;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORLD_HEIGHT = 8'd1;

  typedef struct packed {
    logic signed [23:0] fire_x;
    logic signed [23:0] fire_y;
    logic [22:0]        shot_speed;
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic signed [23:0] target_vx;
    logic signed [23:0] target_vy;
  } ilp_in_t;

  typedef struct packed {
    logic signed [23:0] aim_x;
    logic signed [23:0] aim_y;
    logic               lead_found;
  } ilp_out_t;

  typedef struct packed {
    logic signed [23:0] target_x;
    logic signed [23:0] target_y;
    logic               vx_neg;
    logic               vy_neg;
    logic [23:0]        vx_mag;
    logic [23:0]        vy_mag;
    logic               bypass;
    logic [T_W-1:0]     t;
    logic signed [49:0] p;
  } ilp_side_t;

endpackage

/* rtl/core/ilp_front.sv */
// front stages: differences, products, dot and cross terms, radicand
module ilp_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  ilp_pkg::ilp_in_t        in_data,
  output logic                    out_valid,
  output logic [ilp_pkg::RAD_W-1:0] out_rad,
  output ilp_pkg::ilp_side_t      out_side
);
  import ilp_pkg::*;

  logic [5:0] vld_r;

  logic signed [24:0] s1_dx_r, s1_dy_r;
  logic signed [23:0] s1_vx_r, s1_vy_r, s1_tx_r, s1_ty_r;
  logic [22:0]        s1_vp_r;

  logic signed [24:0] dx_nxt, dy_nxt;

  logic signed [47:0] vxx_w, vyy_w;
  logic signed [49:0] dxdx_w, dydy_w;
  logic signed [48:0] dxvx_w, dyvy_w, dyvx_w, dxvy_w;
  logic [45:0]        w2_w;

  logic [46:0]        s2_vxx_r, s2_vyy_r;
  logic [48:0]        s2_dxdx_r, s2_dydy_r;
  logic signed [48:0] s2_dxvx_r, s2_dyvy_r, s2_dyvx_r, s2_dxvy_r;
  logic [45:0]        s2_w2_r;
  logic signed [23:0] s2_vx_r, s2_vy_r, s2_tx_r, s2_ty_r;

  logic [47:0]        v2_w;
  logic [49:0]        d2_w;
  logic signed [49:0] p_w, q_w;
  logic [49:0]        qm_w;
  ilp_side_t          side_nxt;

  logic [45:0]        s3_w2_r;
  logic [49:0]        s3_d2_r;
  logic [48:0]        s3_qm_r;
  ilp_side_t          s3_side_r;

  logic [47:0]        s4_hh_r, s4_hl_r, s4_lh_r, s4_ll_r;
  logic [47:0]        s4_qhh_r;
  logic [48:0]        s4_qhl_r;
  logic [49:0]        s4_qll_r;
  ilp_side_t          s4_side_r;

  logic [97:0]        a_w, b_w, rad_w;
  logic [97:0]        s5_a_r, s5_b_r;
  ilp_side_t          s5_side_r;

  logic [RAD_W-1:0]   s6_rad_r;
  ilp_side_t          s6_side_r;

  assign dx_nxt = $signed({in_data.target_x[23], in_data.target_x})
                - $signed({in_data.fire_x[23], in_data.fire_x});
  assign dy_nxt = $signed({in_data.target_y[23], in_data.target_y})
                - $signed({in_data.fire_y[23], in_data.fire_y});

  assign vxx_w  = s1_vx_r * s1_vx_r;
  assign vyy_w  = s1_vy_r * s1_vy_r;
  assign dxdx_w = s1_dx_r * s1_dx_r;
  assign dydy_w = s1_dy_r * s1_dy_r;
  assign dxvx_w = s1_dx_r * s1_vx_r;
  assign dyvy_w = s1_dy_r * s1_vy_r;
  assign dyvx_w = s1_dy_r * s1_vx_r;
  assign dxvy_w = s1_dx_r * s1_vy_r;
  assign w2_w   = s1_vp_r * s1_vp_r;

  assign v2_w = {1'b0, s2_vxx_r} + {1'b0, s2_vyy_r};
  assign d2_w = {1'b0, s2_dxdx_r} + {1'b0, s2_dydy_r};
  assign p_w  = s2_dxvx_r + s2_dyvy_r;
  assign q_w  = s2_dyvx_r - s2_dxvy_r;
  assign qm_w = q_w[49] ? 50'(-q_w) : 50'(q_w);

  always_comb begin
    side_nxt.target_x = s2_tx_r;
    side_nxt.target_y = s2_ty_r;
    side_nxt.vx_neg   = s2_vx_r[23];
    side_nxt.vy_neg   = s2_vy_r[23];
    side_nxt.vx_mag   = s2_vx_r[23] ? 24'(-s2_vx_r) : 24'(s2_vx_r);
    side_nxt.vy_mag   = s2_vy_r[23] ? 24'(-s2_vy_r) : 24'(s2_vy_r);
    side_nxt.bypass   = (v2_w == 48'd0) || (v2_w >= {2'b00, s2_w2_r});
    side_nxt.t        = s2_w2_r - v2_w[45:0];
    side_nxt.p        = p_w;
  end

  assign a_w = ({50'd0, s4_hh_r} << 48) + ({50'd0, s4_hl_r} << 23)
             + ({50'd0, s4_lh_r} << 25) + {50'd0, s4_ll_r};
  assign b_w = ({50'd0, s4_qhh_r} << 50) + ({49'd0, s4_qhl_r} << 26)
             + {48'd0, s4_qll_r};
  assign rad_w = s5_a_r - s5_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r <= dx_nxt;
      s1_dy_r <= dy_nxt;
      s1_vx_r <= in_data.target_vx;
      s1_vy_r <= in_data.target_vy;
      s1_tx_r <= in_data.target_x;
      s1_ty_r <= in_data.target_y;
      s1_vp_r <= in_data.shot_speed;

      s2_vxx_r  <= vxx_w[46:0];
      s2_vyy_r  <= vyy_w[46:0];
      s2_dxdx_r <= dxdx_w[48:0];
      s2_dydy_r <= dydy_w[48:0];
      s2_dxvx_r <= dxvx_w;
      s2_dyvy_r <= dyvy_w;
      s2_dyvx_r <= dyvx_w;
      s2_dxvy_r <= dxvy_w;
      s2_w2_r   <= w2_w;
      s2_vx_r   <= s1_vx_r;
      s2_vy_r   <= s1_vy_r;
      s2_tx_r   <= s1_tx_r;
      s2_ty_r   <= s1_ty_r;

      s3_w2_r   <= s2_w2_r;
      s3_d2_r   <= d2_w;
      s3_qm_r   <= qm_w[48:0];
      s3_side_r <= side_nxt;

      s4_hh_r   <= s3_w2_r[45:23] * s3_d2_r[49:25];
      s4_hl_r   <= s3_w2_r[45:23] * s3_d2_r[24:0];
      s4_lh_r   <= s3_w2_r[22:0] * s3_d2_r[49:25];
      s4_ll_r   <= s3_w2_r[22:0] * s3_d2_r[24:0];
      s4_qhh_r  <= s3_qm_r[48:25] * s3_qm_r[48:25];
      s4_qhl_r  <= s3_qm_r[48:25] * s3_qm_r[24:0];
      s4_qll_r  <= s3_qm_r[24:0] * s3_qm_r[24:0];
      s4_side_r <= s3_side_r;

      s5_a_r    <= a_w;
      s5_b_r    <= b_w;
      s5_side_r <= s4_side_r;

      s6_rad_r  <= rad_w[RAD_W-1:0];
      s6_side_r <= s5_side_r;
    end
  end

  assign out_valid = vld_r[5];
  assign out_rad   = s6_rad_r;
  assign out_side  = s6_side_r;

endmodule

/* rtl/core/ilp_sqrt.sv */
// pipelined floor square root, one root bit per stage
module ilp_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ilp_pkg::RAD_W-1:0]  in_rad,
  input  ilp_pkg::ilp_side_t         in_side,
  output logic                       out_valid,
  output logic [ilp_pkg::ROOT_W-1:0] out_root,
  output ilp_pkg::ilp_side_t         out_side
);
  import ilp_pkg::*;

  logic              vld_r  [0:ROOT_W-1];
  logic [RAD_W-1:0]  rad_r  [0:ROOT_W-1];
  logic [REM_W-1:0]  rem_r  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_r [0:ROOT_W-1];
  ilp_side_t         side_r [0:ROOT_W-1];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic              prev_vld;
    logic [RAD_W-1:0]  prev_rad;
    logic [REM_W-1:0]  prev_rem;
    logic [ROOT_W-1:0] prev_root;
    ilp_side_t         prev_side;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign prev_vld  = in_valid;
      assign prev_rad  = in_rad;
      assign prev_rem  = '0;
      assign prev_root = '0;
      assign prev_side = in_side;
    end else begin : g_next
      assign prev_vld  = vld_r[k-1];
      assign prev_rad  = rad_r[k-1];
      assign prev_rem  = rem_r[k-1];
      assign prev_root = root_r[k-1];
      assign prev_side = side_r[k-1];
    end

    assign rem_sh = {prev_rem[REM_W-3:0], prev_rad[2*B+1 -: 2]};
    assign trial  = {1'b0, prev_root, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k]  <= prev_rad;
        rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {prev_root[ROOT_W-2:0], ge};
        side_r[k] <= prev_side;
      end
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

/* rtl/core/ilp_div.sv */
// lead offset: numerator products and pipelined saturating division
module ilp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ilp_pkg::ROOT_W-1:0] in_root,
  input  ilp_pkg::ilp_side_t         in_side,
  output logic                       out_valid,
  output logic [ilp_pkg::QUO_W-1:0]  out_ox,
  output logic [ilp_pkg::QUO_W-1:0]  out_oy,
  output ilp_pkg::ilp_side_t         out_side
);
  import ilp_pkg::*;

  localparam int DW = NUM_W + 13;
  localparam logic [QUO_W-1:0] CAP = QUO_W'(1) << CAP_B;

  logic [3:0]       vld_r;
  logic [PS_W-1:0]  ps_nxt;
  logic [PS_W-1:0]  d1_ps_r;
  ilp_side_t        d1_side_r;
  logic [49:0]      d2_hx_r, d2_hy_r;
  logic [48:0]      d2_lx_r, d2_ly_r;
  ilp_side_t        d2_side_r;
  logic [NUM_W-1:0] d3_nx_r, d3_ny_r;
  ilp_side_t        d3_side_r;
  logic [NUM_W-1:0] d4_nx_r, d4_ny_r;
  logic             d4_satx_r, d4_saty_r;
  ilp_side_t        d4_side_r;

  logic             qv_r   [0:QUO_W-1];
  logic [NUM_W-1:0] rx_r   [0:QUO_W-1];
  logic [NUM_W-1:0] ry_r   [0:QUO_W-1];
  logic [QUO_W-1:0] qx_r   [0:QUO_W-1];
  logic [QUO_W-1:0] qy_r   [0:QUO_W-1];
  logic             sx_r   [0:QUO_W-1];
  logic             sy_r   [0:QUO_W-1];
  ilp_side_t        qside_r[0:QUO_W-1];

  assign ps_nxt = PS_W'($signed({in_side.p[49], in_side.p}) + $signed({3'b000, in_root}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_ps_r   <= ps_nxt;
      d1_side_r <= in_side;

      d2_hx_r   <= d1_side_r.vx_mag * d1_ps_r[50:25];
      d2_lx_r   <= d1_side_r.vx_mag * d1_ps_r[24:0];
      d2_hy_r   <= d1_side_r.vy_mag * d1_ps_r[50:25];
      d2_ly_r   <= d1_side_r.vy_mag * d1_ps_r[24:0];
      d2_side_r <= d1_side_r;

      d3_nx_r   <= ({25'd0, d2_hx_r} << 25) + {26'd0, d2_lx_r};
      d3_ny_r   <= ({25'd0, d2_hy_r} << 25) + {26'd0, d2_ly_r};
      d3_side_r <= d2_side_r;

      d4_nx_r   <= d3_nx_r;
      d4_ny_r   <= d3_ny_r;
      d4_satx_r <= ({13'd0, d3_nx_r[NUM_W-1:QUO_W]} >= d3_side_r.t);
      d4_saty_r <= ({13'd0, d3_ny_r[NUM_W-1:QUO_W]} >= d3_side_r.t);
      d4_side_r <= d3_side_r;
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int I = QUO_W - 1 - j;
    logic             pv;
    logic [NUM_W-1:0] prx, pry;
    logic [QUO_W-1:0] pqx, pqy;
    logic             psx, psy;
    ilp_side_t        pside;
    logic [DW-1:0]    dv, ex, ey, subx, suby;
    logic             gex, gey;

    if (j == 0) begin : g_first
      assign pv    = vld_r[3];
      assign prx   = d4_nx_r;
      assign pry   = d4_ny_r;
      assign pqx   = '0;
      assign pqy   = '0;
      assign psx   = d4_satx_r;
      assign psy   = d4_saty_r;
      assign pside = d4_side_r;
    end else begin : g_next
      assign pv    = qv_r[j-1];
      assign prx   = rx_r[j-1];
      assign pry   = ry_r[j-1];
      assign pqx   = qx_r[j-1];
      assign pqy   = qy_r[j-1];
      assign psx   = sx_r[j-1];
      assign psy   = sy_r[j-1];
      assign pside = qside_r[j-1];
    end

    assign dv   = {{(DW-T_W){1'b0}}, pside.t} << I;
    assign ex   = {{(DW-NUM_W){1'b0}}, prx};
    assign ey   = {{(DW-NUM_W){1'b0}}, pry};
    assign gex  = (ex >= dv);
    assign gey  = (ey >= dv);
    assign subx = ex - dv;
    assign suby = ey - dv;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        qv_r[j] <= 1'b0;
      end else if (en) begin
        qv_r[j] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_r[j]    <= gex ? subx[NUM_W-1:0] : prx;
        ry_r[j]    <= gey ? suby[NUM_W-1:0] : pry;
        qx_r[j]    <= {pqx[QUO_W-2:0], gex};
        qy_r[j]    <= {pqy[QUO_W-2:0], gey};
        sx_r[j]    <= psx;
        sy_r[j]    <= psy;
        qside_r[j] <= pside;
      end
    end
  end

  assign out_valid = qv_r[QUO_W-1];
  assign out_side  = qside_r[QUO_W-1];
  assign out_ox = (sx_r[QUO_W-1] || (qx_r[QUO_W-1] > CAP)) ? CAP : qx_r[QUO_W-1];
  assign out_oy = (sy_r[QUO_W-1] || (qy_r[QUO_W-1] > CAP)) ? CAP : qy_r[QUO_W-1];

endmodule

/* rtl/core/intercept_lead_point_unit.sv */
// top level of the intercept lead point unit: pipeline, clamp and world registers
// the pipeline runs the front, root, divide and clamp stages in that order from input transfer to result
// throughput: one item per cycle while the output is not stalled; the root and divide units take one bit per stage
// a stalled output holds the whole pipeline in place
// reset: synchronous active low, clears valid bits and sets both world limits to 8388607
module intercept_lead_point_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ilp_pkg::ilp_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ilp_pkg::ilp_out_t            out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ilp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [22:0]                  cfg_data
);
  import ilp_pkg::*;

  logic               en;
  logic               fr_valid, sq_valid, dv_valid;
  logic [RAD_W-1:0]   fr_rad;
  ilp_side_t          fr_side, sq_side, dv_side;
  logic [ROOT_W-1:0]  sq_root;
  logic [QUO_W-1:0]   dv_ox, dv_oy;
  logic [22:0]        world_w_r, world_h_r;
  logic               out_valid_r;
  ilp_out_t           out_data_r, out_nxt;
  logic signed [43:0] ax_w, ay_w;

  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  ilp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (fr_valid),
    .out_rad   (fr_rad),
    .out_side  (fr_side)
  );

  ilp_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_rad    (fr_rad),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  ilp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_side   (sq_side),
    .out_valid (dv_valid),
    .out_ox    (dv_ox),
    .out_oy    (dv_oy),
    .out_side  (dv_side)
  );

  assign ax_w = dv_side.vx_neg
              ? ($signed({{20{dv_side.target_x[23]}}, dv_side.target_x})
                 - $signed({2'b00, dv_ox}))
              : ($signed({{20{dv_side.target_x[23]}}, dv_side.target_x})
                 + $signed({2'b00, dv_ox}));
  assign ay_w = dv_side.vy_neg
              ? ($signed({{20{dv_side.target_y[23]}}, dv_side.target_y})
                 - $signed({2'b00, dv_oy}))
              : ($signed({{20{dv_side.target_y[23]}}, dv_side.target_y})
                 + $signed({2'b00, dv_oy}));

  always_comb begin
    if (dv_side.bypass) begin
      out_nxt.aim_x      = dv_side.target_x;
      out_nxt.aim_y      = dv_side.target_y;
      out_nxt.lead_found = 1'b0;
    end else begin
      if (ax_w < 0) begin
        out_nxt.aim_x = '0;
      end else if (ax_w > $signed({21'd0, world_w_r})) begin
        out_nxt.aim_x = {1'b0, world_w_r};
      end else begin
        out_nxt.aim_x = ax_w[23:0];
      end
      if (ay_w < 0) begin
        out_nxt.aim_y = '0;
      end else if (ay_w > $signed({21'd0, world_h_r})) begin
        out_nxt.aim_y = {1'b0, world_h_r};
      end else begin
        out_nxt.aim_y = ay_w[23:0];
      end
      out_nxt.lead_found = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      world_w_r   <= 23'h7fffff;
      world_h_r   <= 23'h7fffff;
    end else begin
      if (en) begin
        out_valid_r <= dv_valid;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WORLD_WIDTH:  world_w_r <= cfg_data;
          CFG_WORLD_HEIGHT: world_h_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
